/* hw/rtl/icalc_pkg.sv */
// Shared types, constants and codes for the integer calculator with decimal output.
`default_nettype none

package icalc_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int MAX_CHARS       = 11;
   localparam int CHAR_WIDTH      = 8;
   localparam int OP_WIDTH        = 3;
   localparam int BCD_DIGITS      = (DATA_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_BITS        = BCD_DIGITS * 4;
   localparam int CNT_WIDTH       = $clog2(DATA_WIDTH + 1);
   localparam int DIGIT_CNT_WIDTH = $clog2(BCD_DIGITS + 1);
   localparam int CHAR_CNT_WIDTH  = $clog2(MAX_CHARS + 1);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_MOD = 3'd4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NONE  = 8'h00;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      CLS_ADD,
      CLS_SUB,
      CLS_MUL,
      CLS_DIV,
      CLS_MOD,
      CLS_PASS,
      CLS_ZERO_DIV
   } cls_type;

   typedef struct packed {
      word_type left;
      word_type right;
      cls_type  cls;
   } job_type;

   typedef struct packed {
      logic    empty;
      job_type job;
   } queue_out_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_DIV_END,
      ST_FIX,
      ST_CONV,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT,
      ST_ERR
   } back_state_type;

endpackage

`default_nettype wire

/* hw/rtl/icalc_front.sv */
// Front stage: registers each request and classifies its operation.
`default_nettype none

module icalc_front (
   input  logic                clock,
   input  logic                reset,
   input  icalc_pkg::word_type req_left_operand,
   input  icalc_pkg::word_type req_right_operand,
   input  logic [icalc_pkg::OP_WIDTH-1:0] req_op,
   input  logic                req_push,
   output logic                req_full,
   input  logic                q_full,
   output logic                q_push,
   output icalc_pkg::job_type  q_job
);
   import icalc_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   cls_type cls;
   logic    advance;

   always_comb begin
      case (req_op)
         OP_ADD:  cls = CLS_ADD;
         OP_SUB:  cls = CLS_SUB;
         OP_MUL:  cls = CLS_MUL;
         OP_DIV:  cls = (req_right_operand == '0) ? CLS_ZERO_DIV : CLS_DIV;
         OP_MOD:  cls = (req_right_operand == '0) ? CLS_ZERO_DIV : CLS_MOD;
         default: cls = CLS_PASS;
      endcase
   end

   assign advance  = !valid_ff || !q_full;
   assign req_full = !advance;
   assign q_push   = valid_ff && !q_full;
   assign q_job    = job_ff;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (advance) begin
         valid_in = req_push;
         if (req_push) begin
            job_in.left  = req_left_operand;
            job_in.right = req_right_operand;
            job_in.cls   = cls;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/icalc_queue.sv */
// Short request queue between the front stage and the execution unit.
`default_nettype none

module icalc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  icalc_pkg::job_type       push_job,
   output logic                     full,
   input  logic                     pop,
   output icalc_pkg::queue_out_type q_out
);
   import icalc_pkg::*;

   job_type                 mem [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full        = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign q_out.empty = (count_ff == '0);
   assign q_out.job   = mem[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && !q_out.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

/* hw/rtl/icalc_back.sv */
// Execution unit: arithmetic, serial divider, binary-to-decimal conversion and character output.
`default_nettype none

module icalc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  icalc_pkg::queue_out_type      q_out,
   output logic                          q_pop,
   output logic [icalc_pkg::CHAR_WIDTH-1:0] rsp_ascii_char,
   output logic                          rsp_last_char,
   output logic                          rsp_div_error,
   output logic                          rsp_empty,
   input  logic                          rsp_pop
);
   import icalc_pkg::*;

   back_state_type              state_ff, state_in;
   word_type                    left_ff, left_in;
   word_type                    right_ff, right_in;
   word_type                    res_ff, res_in;
   word_type                    rem_ff, rem_in;
   cls_type                     cls_ff, cls_in;
   logic                        lneg_ff, lneg_in;
   logic                        rneg_ff, rneg_in;
   logic                        neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]        cnt_ff, cnt_in;
   logic [BCD_BITS-1:0]         bcd_ff, bcd_in;
   logic [DIGIT_CNT_WIDTH-1:0]  dig_ff, dig_in;
   logic [CHAR_CNT_WIDTH-1:0]   chars_ff, chars_in;
   logic                        out_valid_ff, out_valid_in;
   logic [CHAR_WIDTH-1:0]       out_char_ff, out_char_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_err_ff, out_err_in;

   logic [DATA_WIDTH:0]         rem_shift;
   logic [DATA_WIDTH:0]         rem_diff;
   logic                        fits;
   logic [BCD_BITS-1:0]         bcd_adj;
   logic [3:0]                  top_digit;
   logic                        slot;
   logic                        last_emit;
   logic                        last_sign;
   word_type                    prod;

   assign rem_shift = {rem_ff, res_ff[DATA_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, right_ff};
   assign fits      = !rem_diff[DATA_WIDTH];
   assign prod      = word_type'(left_ff * right_ff);
   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];
   assign slot      = !out_valid_ff || rsp_pop;
   assign last_emit = (dig_ff == DIGIT_CNT_WIDTH'(1)) ||
                      (chars_ff == CHAR_CNT_WIDTH'(MAX_CHARS - 1));
   assign last_sign = (chars_ff == CHAR_CNT_WIDTH'(MAX_CHARS - 1));
   assign q_pop     = (state_ff == ST_IDLE) && !q_out.empty;

   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? bcd_ff[d*4 +: 4] + 4'd3
                                                       : bcd_ff[d*4 +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      res_in       = res_ff;
      rem_in       = rem_ff;
      cls_in       = cls_ff;
      lneg_in      = lneg_ff;
      rneg_in      = rneg_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      bcd_in       = bcd_ff;
      dig_in       = dig_ff;
      chars_in     = chars_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_out.empty) begin
               left_in  = q_out.job.left;
               right_in = q_out.job.right;
               cls_in   = q_out.job.cls;
               lneg_in  = q_out.job.left[DATA_WIDTH-1];
               rneg_in  = q_out.job.right[DATA_WIDTH-1];
               case (q_out.job.cls)
                  CLS_DIV, CLS_MOD: begin
                     res_in   = q_out.job.left[DATA_WIDTH-1] ? ~q_out.job.left + 1'b1
                                                             : q_out.job.left;
                     right_in = q_out.job.right[DATA_WIDTH-1] ? ~q_out.job.right + 1'b1
                                                              : q_out.job.right;
                     rem_in   = '0;
                     cnt_in   = CNT_WIDTH'(DATA_WIDTH);
                     state_in = ST_DIV;
                  end
                  CLS_ZERO_DIV: begin
                     state_in = ST_ERR;
                  end
                  default: begin
                     state_in = ST_EXEC;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            case (cls_ff)
               CLS_ADD: res_in = left_ff + right_ff;
               CLS_SUB: res_in = left_ff - right_ff;
               CLS_MUL: res_in = prod;
               default: res_in = left_ff;
            endcase
            state_in = ST_FIX;
         end
         ST_DIV: begin
            res_in = {res_ff[DATA_WIDTH-2:0], fits};
            rem_in = fits ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            if (cls_ff == CLS_DIV) begin
               res_in = (lneg_ff ^ rneg_ff) ? ~res_ff + 1'b1 : res_ff;
            end else begin
               res_in = lneg_ff ? ~rem_ff + 1'b1 : rem_ff;
            end
            state_in = ST_FIX;
         end
         ST_FIX: begin
            neg_in   = res_ff[DATA_WIDTH-1];
            left_in  = res_ff[DATA_WIDTH-1] ? ~res_ff + 1'b1 : res_ff;
            bcd_in   = '0;
            cnt_in   = CNT_WIDTH'(DATA_WIDTH);
            state_in = ST_CONV;
         end
         ST_CONV: begin
            bcd_in  = {bcd_adj[BCD_BITS-2:0], left_ff[DATA_WIDTH-1]};
            left_in = {left_ff[DATA_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) begin
               dig_in   = DIGIT_CNT_WIDTH'(BCD_DIGITS);
               chars_in = '0;
               state_in = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (slot) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = last_sign;
               out_err_in   = 1'b0;
               chars_in     = chars_ff + 1'b1;
               state_in     = last_sign ? ST_IDLE : ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && dig_ff != DIGIT_CNT_WIDTH'(1)) begin
               bcd_in = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_in = dig_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_ZERO + {4'd0, top_digit};
               out_last_in  = last_emit;
               out_err_in   = 1'b0;
               bcd_in       = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_in       = dig_ff - 1'b1;
               chars_in     = chars_ff + 1'b1;
               if (last_emit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (slot) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_NONE;
               out_last_in  = 1'b1;
               out_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      left_ff     <= left_in;
      right_ff    <= right_in;
      res_ff      <= res_in;
      rem_ff      <= rem_in;
      cls_ff      <= cls_in;
      lneg_ff     <= lneg_in;
      rneg_ff     <= rneg_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      bcd_ff      <= bcd_in;
      dig_ff      <= dig_in;
      chars_ff    <= chars_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_ascii_char = out_char_ff;
   assign rsp_last_char  = out_last_ff;
   assign rsp_div_error  = out_err_ff;

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_err_ff |-> out_last_ff && out_char_ff == CHAR_NONE)
      else $error("error response not a single blank last character");

   a_chars_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_SIGN) |-> chars_ff < CHAR_CNT_WIDTH'(MAX_CHARS))
      else $error("character count past limit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_char_ff))
      else $error("held response overwritten");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != ST_IDLE)
      else $error("request taken without leaving idle");

   a_loop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_CONV) |-> cnt_ff != '0)
      else $error("shift loop count underflow");

endmodule

`default_nettype wire

/* hw/rtl/integer_calculator_decimal_out.sv */
// Each request passes the front register and the queue; the execution unit then computes
// the result directly for add, subtract, multiply and pass, or with the bit-serial divider
// for divide and modulo; a divide or modulo by zero answers with its single response.
// Results pass the binary-to-decimal shift and leave as a minus sign if negative, then digits
// without leading zeros; a new request leaves the queue only after the last character.
// Reset: synchronous, active high; empties the queue and drops any response in progress.
`default_nettype none

module integer_calculator_decimal_out (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic signed [icalc_pkg::DATA_WIDTH-1:0]     req_left_operand,
   input  logic signed [icalc_pkg::DATA_WIDTH-1:0]     req_right_operand,
   input  logic [icalc_pkg::OP_WIDTH-1:0]              req_op,
   input  logic                                        req_push,
   output logic                                        req_full,
   output logic [icalc_pkg::CHAR_WIDTH-1:0]            rsp_ascii_char,
   output logic                                        rsp_last_char,
   output logic                                        rsp_div_error,
   output logic                                        rsp_empty,
   input  logic                                        rsp_pop
);
   import icalc_pkg::*;

   logic          q_full;
   logic          q_push;
   job_type       q_job;
   logic          q_pop;
   queue_out_type q_out;

   icalc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_left_operand  (req_left_operand),
      .req_right_operand (req_right_operand),
      .req_op            (req_op),
      .req_push          (req_push),
      .req_full          (req_full),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (q_job)
   );

   icalc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .q_out    (q_out)
   );

   icalc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_out          (q_out),
      .q_pop          (q_pop),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char),
      .rsp_div_error  (rsp_div_error),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

endmodule

`default_nettype wire
